@@ rtl/ppf_pkg.sv @@
// ppf_pkg: widths, register indexes, reset values and pipeline types for the
// particle pair force kernel. No dependencies; imported by the kernel and its checker.
package ppf_pkg;

  localparam int POS_FRAC_BITS = 16;
  localparam int POS_INT_BITS  = 8;
  localparam int POS_W         = POS_INT_BITS + POS_FRAC_BITS;
  localparam int SQ_W          = 2 * POS_W;
  localparam int SQ1_W         = SQ_W + 1;

  localparam int ATT_W    = 16;
  localparam int ATT_FRAC = 14;
  localparam int EQ_W     = 16;
  localparam int TS_W     = 16;
  localparam int OUT_W    = 32;

  // normalized values are Q1.16 and may reach exactly one
  localparam int FRAC16 = 16;
  localparam int Q_W    = FRAC16 + 1;
  localparam int DIV_W  = POS_W + FRAC16;
  localparam int NUM_W  = Q_W + FRAC16;
  localparam int F_W    = Q_W + 1;
  localparam int K_W    = POS_W + F_W - POS_FRAC_BITS;
  localparam int M_W    = K_W + 1;
  localparam int SAT_W  = (M_W > OUT_W) ? M_W + 1 : OUT_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (POS_W > EQ_W) ? POS_W : EQ_W;

  localparam logic [CFG_IDX_W-1:0] CFG_EQUILIBRIUM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = CFG_IDX_W'(2);

  localparam logic [EQ_W-1:0]  EQ_RESET     = EQ_W'(19661);
  localparam logic [POS_W-1:0] RADIUS_RESET = POS_W'(1) << POS_FRAC_BITS;
  localparam logic [TS_W-1:0]  TS_RESET     = TS_W'(655);

  localparam logic [Q_W-1:0]   Q_ONE       = Q_W'(1) << FRAC16;
  localparam logic [OUT_W-1:0] SAT_POS     = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [SAT_W-1:0] SAT_NEG_MAG = SAT_W'(1) << (OUT_W - 1);

  // carried through squaring, root and first divisions
  typedef struct packed {
    logic [POS_W-1:0] adx;
    logic [POS_W-1:0] ady;
    logic             negx;
    logic             negy;
    logic             aneg;
    logic [ATT_W-1:0] amag;
    logic             inr;
    logic             zero;
  } ppf_side_t;

  // carried from the force division to the output
  typedef struct packed {
    logic [Q_W-1:0]   mx;
    logic [Q_W-1:0]   my;
    logic             negx;
    logic             negy;
    logic             inr;
    logic             zero;
    logic             rep;
    logic             active;
    logic             fneg;
    logic [ATT_W-1:0] amag;
  } ppf_tail_t;

endpackage

@@ rtl/particle_pair_force_kernel.sv @@
// particle_pair_force_kernel: pipelined pair force, distance root, normalizing
// divisions and per-axis scaling. Depends on ppf_pkg.
//
// channel  dir  handshake            word
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in   in_valid/in_ready    source/target positions, attraction, same flag
// out      out  out_valid/out_ready  delta_vx, delta_vy, in_range
//
// one pair per cycle while the output is not stalled; the pipeline depth comes
// from the bit-per-stage square root and the two restoring dividers
// (17 and 16 quotient stages). synchronous reset clears the valid bits and
// loads the register defaults. a stalled output freezes the whole pipeline;
// in_ready stays high whenever the output register is empty or being taken.
module particle_pair_force_kernel
  import ppf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [POS_W-1:0]        in_source_x,
  input  logic [POS_W-1:0]        in_source_y,
  input  logic [POS_W-1:0]        in_target_x,
  input  logic [POS_W-1:0]        in_target_y,
  input  logic signed [ATT_W-1:0] in_attraction,
  input  logic                    in_same_particle,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_delta_vx,
  output logic signed [OUT_W-1:0] out_delta_vy,
  output logic                    out_in_range
);

  function automatic logic [OUT_W-1:0] sat_signed(input logic [M_W-1:0] mag,
                                                  input logic neg);
    logic [SAT_W-1:0] m;
    m = SAT_W'(mag);
    if (!neg) begin
      return (m > SAT_W'(SAT_POS)) ? SAT_POS : m[OUT_W-1:0];
    end
    if (m > SAT_NEG_MAG) begin
      m = SAT_NEG_MAG;
    end
    return OUT_W'(SAT_W'(0) - m);
  endfunction

  // configuration registers
  logic [EQ_W-1:0]  eq_r;
  logic [POS_W-1:0] radius_r;
  logic [TS_W-1:0]  ts_r;
  logic [SQ_W-1:0]  rsq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eq_r     <= EQ_RESET;
      radius_r <= RADIUS_RESET;
      ts_r     <= TS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EQUILIBRIUM: eq_r     <= cfg_data[EQ_W-1:0];
        CFG_RADIUS:      radius_r <= cfg_data[POS_W-1:0];
        CFG_TIME_STEP:   ts_r     <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rsq_r <= SQ_W'(radius_r) * SQ_W'(radius_r);
  end

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage a: axis distances
  logic      a_vld_r;
  ppf_side_t a_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  logic a_same_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sb_r.negx <= in_source_x < in_target_x;
      a_sb_r.negy <= in_source_y < in_target_y;
      a_sb_r.adx  <= (in_source_x < in_target_x) ? in_target_x - in_source_x
                                                 : in_source_x - in_target_x;
      a_sb_r.ady  <= (in_source_y < in_target_y) ? in_target_y - in_source_y
                                                 : in_source_y - in_target_y;
      a_sb_r.aneg <= in_attraction[ATT_W-1];
      a_sb_r.amag <= in_attraction[ATT_W-1] ? ATT_W'(-in_attraction)
                                            : ATT_W'(in_attraction);
      a_sb_r.inr  <= 1'b0;
      a_sb_r.zero <= 1'b0;
      a_same_r    <= in_same_particle;
    end
  end

  // stage b: squares and box test
  logic            b_vld_r;
  logic [SQ_W-1:0] b_sqx_r;
  logic [SQ_W-1:0] b_sqy_r;
  logic            b_kill_r;
  ppf_side_t       b_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sqx_r  <= SQ_W'(a_sb_r.adx) * SQ_W'(a_sb_r.adx);
      b_sqy_r  <= SQ_W'(a_sb_r.ady) * SQ_W'(a_sb_r.ady);
      b_kill_r <= a_same_r || (radius_r == '0) || (a_sb_r.adx > radius_r)
                  || (a_sb_r.ady > radius_r);
      b_sb_r   <= a_sb_r;
    end
  end

  // stage c: squared distance against squared radius, feeds the root
  logic [SQ_W:0] c_d2;
  logic          c_out;
  ppf_side_t     c_sb;

  assign c_d2  = {1'b0, b_sqx_r} + {1'b0, b_sqy_r};
  assign c_out = b_kill_r || (c_d2 > {1'b0, rsq_r});

  always_comb begin
    c_sb      = b_sb_r;
    c_sb.inr  = !c_out;
    c_sb.zero = c_out;
  end

  logic             sq_vld_r  [POS_W+1];
  logic [SQ_W-1:0]  sq_rem_r  [POS_W+1];
  logic [POS_W-1:0] sq_root_r [POS_W+1];
  ppf_side_t        sq_sb_r   [POS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_r[0] <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem_r[0]  <= c_d2[SQ_W-1:0];
      sq_root_r[0] <= '0;
      sq_sb_r[0]   <= c_sb;
    end
  end

  // one root bit per stage, remainder kept as d2 - root^2
  for (genvar s = 0; s < POS_W; s++) begin : g_sqrt
    localparam int BIT = POS_W - 1 - s;
    logic [SQ_W:0] term;
    logic          take;

    assign term = ({1'b0, {POS_W{1'b0}}, sq_root_r[s]} << (BIT + 1))
                  | (SQ1_W'(1) << (2 * BIT));
    assign take = {1'b0, sq_rem_r[s]} >= term;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[s+1] <= sq_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[s+1]  <= take ? sq_rem_r[s] - term[SQ_W-1:0] : sq_rem_r[s];
        sq_root_r[s+1] <= take ? (sq_root_r[s] | (POS_W'(1) << BIT)) : sq_root_r[s];
        sq_sb_r[s+1]   <= sq_sb_r[s];
      end
    end
  end

  // first divisions: n = dist/r, mx = adx/dist, my = ady/dist, all Q1.16
  logic [POS_W-1:0] dist_val;
  ppf_side_t        dv_sb0;

  assign dist_val = sq_root_r[POS_W];

  always_comb begin
    dv_sb0      = sq_sb_r[POS_W];
    dv_sb0.zero = sq_sb_r[POS_W].zero || (dist_val == '0);
  end

  logic             dv_vld_r  [Q_W+1];
  logic [DIV_W-1:0] dv_nrem_r [Q_W+1];
  logic [DIV_W-1:0] dv_xrem_r [Q_W+1];
  logic [DIV_W-1:0] dv_yrem_r [Q_W+1];
  logic [Q_W-1:0]   dv_nq_r   [Q_W+1];
  logic [Q_W-1:0]   dv_xq_r   [Q_W+1];
  logic [Q_W-1:0]   dv_yq_r   [Q_W+1];
  logic [POS_W-1:0] dv_dist_r [Q_W+1];
  ppf_side_t        dv_sb_r   [Q_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= sq_vld_r[POS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_nrem_r[0] <= {dist_val, {FRAC16{1'b0}}};
      dv_xrem_r[0] <= {dv_sb0.adx, {FRAC16{1'b0}}};
      dv_yrem_r[0] <= {dv_sb0.ady, {FRAC16{1'b0}}};
      dv_nq_r[0]   <= '0;
      dv_xq_r[0]   <= '0;
      dv_yq_r[0]   <= '0;
      dv_dist_r[0] <= dist_val;
      dv_sb_r[0]   <= dv_sb0;
    end
  end

  for (genvar t = 0; t < Q_W; t++) begin : g_div1
    localparam int J = Q_W - 1 - t;
    logic [DIV_W:0] rsh;
    logic [DIV_W:0] dsh;
    logic           tn, tx, ty;

    assign rsh = (DIV_W+1)'(radius_r) << J;
    assign dsh = (DIV_W+1)'(dv_dist_r[t]) << J;
    assign tn  = {1'b0, dv_nrem_r[t]} >= rsh;
    assign tx  = {1'b0, dv_xrem_r[t]} >= dsh;
    assign ty  = {1'b0, dv_yrem_r[t]} >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[t+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[t+1] <= dv_vld_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_nrem_r[t+1] <= tn ? dv_nrem_r[t] - rsh[DIV_W-1:0] : dv_nrem_r[t];
        dv_xrem_r[t+1] <= tx ? dv_xrem_r[t] - dsh[DIV_W-1:0] : dv_xrem_r[t];
        dv_yrem_r[t+1] <= ty ? dv_yrem_r[t] - dsh[DIV_W-1:0] : dv_yrem_r[t];
        dv_nq_r[t+1]   <= tn ? (dv_nq_r[t] | (Q_W'(1) << J)) : dv_nq_r[t];
        dv_xq_r[t+1]   <= tx ? (dv_xq_r[t] | (Q_W'(1) << J)) : dv_xq_r[t];
        dv_yq_r[t+1]   <= ty ? (dv_yq_r[t] | (Q_W'(1) << J)) : dv_yq_r[t];
        dv_dist_r[t+1] <= dv_dist_r[t];
        dv_sb_r[t+1]   <= dv_sb_r[t];
      end
    end
  end

  // zone select: repulsion divides n by eq, attraction divides the
  // triangle offset by 1 - eq
  logic [Q_W-1:0] p_n;
  logic [Q_W-1:0] p_eq;
  logic           p_rep;
  logic           p_att;
  logic [Q_W:0]   p_twice;
  logic [Q_W:0]   p_base;
  logic [Q_W:0]   p_tdiff;
  logic [Q_W-1:0] p_num;
  logic [Q_W-1:0] p_den;
  ppf_side_t      p_sb;
  ppf_tail_t      p_tail;

  assign p_n     = dv_nq_r[Q_W];
  assign p_sb    = dv_sb_r[Q_W];
  assign p_eq    = {1'b0, eq_r};
  assign p_rep   = p_n < p_eq;
  assign p_att   = (p_n > p_eq) && (p_n < Q_ONE);
  assign p_twice = {p_n, 1'b0};
  assign p_base  = {1'b0, Q_ONE} + {1'b0, p_eq};
  assign p_tdiff = (p_twice >= p_base) ? p_twice - p_base : p_base - p_twice;
  assign p_num   = p_rep ? p_n : p_tdiff[Q_W-1:0];
  assign p_den   = p_rep ? p_eq : Q_ONE - p_eq;

  always_comb begin
    p_tail.mx     = dv_xq_r[Q_W];
    p_tail.my     = dv_yq_r[Q_W];
    p_tail.negx   = p_sb.negx;
    p_tail.negy   = p_sb.negy;
    p_tail.inr    = p_sb.inr;
    p_tail.zero   = p_sb.zero;
    p_tail.rep    = p_rep;
    p_tail.active = p_rep || p_att;
    p_tail.fneg   = p_rep || p_sb.aneg;
    p_tail.amag   = p_sb.amag;
  end

  logic             e2_vld_r [FRAC16+1];
  logic [NUM_W-1:0] e2_rem_r [FRAC16+1];
  logic [Q_W-1:0]   e2_den_r [FRAC16+1];
  logic [FRAC16-1:0] e2_q_r  [FRAC16+1];
  ppf_tail_t        e2_sb_r  [FRAC16+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_vld_r[0] <= 1'b0;
    end else if (adv) begin
      e2_vld_r[0] <= dv_vld_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_rem_r[0] <= {p_num, {FRAC16{1'b0}}};
      e2_den_r[0] <= p_den;
      e2_q_r[0]   <= '0;
      e2_sb_r[0]  <= p_tail;
    end
  end

  for (genvar t = 0; t < FRAC16; t++) begin : g_div2
    localparam int J = FRAC16 - 1 - t;
    logic [NUM_W:0] dsh;
    logic           take;

    assign dsh  = (NUM_W+1)'(e2_den_r[t]) << J;
    assign take = {1'b0, e2_rem_r[t]} >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        e2_vld_r[t+1] <= 1'b0;
      end else if (adv) begin
        e2_vld_r[t+1] <= e2_vld_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        e2_rem_r[t+1] <= take ? e2_rem_r[t] - dsh[NUM_W-1:0] : e2_rem_r[t];
        e2_den_r[t+1] <= e2_den_r[t];
        e2_q_r[t+1]   <= take ? (e2_q_r[t] | (FRAC16'(1) << J)) : e2_q_r[t];
        e2_sb_r[t+1]  <= e2_sb_r[t];
      end
    end
  end

  // stage f: force magnitude
  logic [Q_W-1:0]       f_g;
  logic [ATT_W+Q_W-1:0] f_prod;
  ppf_tail_t            f_in;

  assign f_in   = e2_sb_r[FRAC16];
  assign f_g    = Q_ONE - {1'b0, e2_q_r[FRAC16]};
  assign f_prod = (ATT_W+Q_W)'(f_in.amag) * (ATT_W+Q_W)'(f_g);

  logic           f_vld_r;
  logic [F_W-1:0] f_fmag_r;
  ppf_tail_t      f_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= e2_vld_r[FRAC16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!f_in.active) begin
        f_fmag_r <= '0;
      end else if (f_in.rep) begin
        f_fmag_r <= F_W'(f_g);
      end else begin
        f_fmag_r <= F_W'(f_prod >> ATT_FRAC);
      end
      f_sb_r <= f_in;
    end
  end

  // stage k: scale by radius
  logic [POS_W+F_W-1:0] k_prod;
  logic                 k_vld_r;
  logic [K_W-1:0]       k_k_r;
  ppf_tail_t            k_sb_r;

  assign k_prod = (POS_W+F_W)'(radius_r) * (POS_W+F_W)'(f_fmag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_vld_r <= 1'b0;
    end else if (adv) begin
      k_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_k_r  <= K_W'(k_prod >> POS_FRAC_BITS);
      k_sb_r <= f_sb_r;
    end
  end

  // stage m1: unit direction times k
  logic [Q_W+K_W-1:0] m1_px;
  logic [Q_W+K_W-1:0] m1_py;
  logic               m1_vld_r;
  logic [M_W-1:0]     m1_x_r;
  logic [M_W-1:0]     m1_y_r;
  ppf_tail_t          m1_sb_r;

  assign m1_px = (Q_W+K_W)'(k_sb_r.mx) * (Q_W+K_W)'(k_k_r);
  assign m1_py = (Q_W+K_W)'(k_sb_r.my) * (Q_W+K_W)'(k_k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r <= k_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_x_r  <= M_W'(m1_px >> FRAC16);
      m1_y_r  <= M_W'(m1_py >> FRAC16);
      m1_sb_r <= k_sb_r;
    end
  end

  // stage m2: time step
  logic [M_W+TS_W-1:0] m2_px;
  logic [M_W+TS_W-1:0] m2_py;
  logic                m2_vld_r;
  logic [M_W-1:0]      m2_x_r;
  logic [M_W-1:0]      m2_y_r;
  ppf_tail_t           m2_sb_r;

  assign m2_px = (M_W+TS_W)'(m1_x_r) * (M_W+TS_W)'(ts_r);
  assign m2_py = (M_W+TS_W)'(m1_y_r) * (M_W+TS_W)'(ts_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (adv) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_x_r  <= M_W'(m2_px >> FRAC16);
      m2_y_r  <= M_W'(m2_py >> FRAC16);
      m2_sb_r <= m1_sb_r;
    end
  end

  // output register: sign, saturation, forced zero
  logic [OUT_W-1:0] out_dvx_r;
  logic [OUT_W-1:0] out_dvy_r;
  logic             out_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (m2_sb_r.zero) begin
        out_dvx_r <= '0;
        out_dvy_r <= '0;
      end else begin
        out_dvx_r <= sat_signed(m2_x_r, m2_sb_r.negx ^ m2_sb_r.fneg);
        out_dvy_r <= sat_signed(m2_y_r, m2_sb_r.negy ^ m2_sb_r.fneg);
      end
      out_inr_r <= m2_sb_r.inr;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_delta_vx = $signed(out_dvx_r);
  assign out_delta_vy = $signed(out_dvy_r);
  assign out_in_range = out_inr_r;

endmodule

@@ rtl/ppf_checker.sv @@
// ppf_checker: port-level checks on the pair force kernel, attached by bind.
// Depends on ppf_pkg and particle_pair_force_kernel.
module ppf_checker
  import ppf_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_delta_vx,
  input logic signed [OUT_W-1:0] out_delta_vy,
  input logic                    out_in_range
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_delta_vx) && $stable(out_delta_vy)
                                && $stable(out_in_range))
    else $error("output word changed while stalled");

  // a pair outside the radius carries no force
  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> (out_delta_vx == '0) && (out_delta_vy == '0))
    else $error("nonzero force on out of range pair");

  // the pipe only holds back input when the output word is stuck
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind particle_pair_force_kernel ppf_checker u_ppf_checker (.*);

@@ tb/sv/tb_particle_pair_force_kernel.sv @@
// tb_particle_pair_force_kernel: self-checking bench for the pair force kernel.
// Depends on ppf_pkg and particle_pair_force_kernel; predicts every word with a
// bit-true scoreboard and compares the results in order.
`timescale 1ns / 100ps

module tb_particle_pair_force_kernel;
  import ppf_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] vx;
    logic signed [OUT_W-1:0] vy;
    logic                    inr;
  } force_word_t;

  class force_scoreboard;
    longint unsigned eq_reg, radius_reg, step_reg;
    force_word_t     pending[$];
    int              errors;

    function new();
      eq_reg = EQ_RESET;
      radius_reg = RADIUS_RESET;
      step_reg = TS_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
      case (idx)
        CFG_EQUILIBRIUM: eq_reg = val & 64'hFFFF;
        CFG_RADIUS:      radius_reg = val & 64'hFFFFFF;
        CFG_TIME_STEP:   step_reg = val & 64'hFFFF;
        default: ;
      endcase
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [OUT_W-1:0] scale_axis(longint unsigned d, bit neg_d,
                                          longint unsigned dist_val,
                                          longint unsigned k, bit neg_f);
      longint unsigned m;
      m = (d << 16) / dist_val;
      m = (m * k) >> 16;
      m = (m * step_reg) >> 16;
      if (neg_d == neg_f) return (m > 64'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
      if (m > 64'h80000000) m = 64'h80000000;
      return -m[31:0];
    endfunction

    function void note_pair(longint unsigned sx, longint unsigned sy, longint unsigned tx,
                            longint unsigned ty, logic [ATT_W-1:0] att, bit same);
      force_word_t     w;
      longint unsigned r, adx, ady, d2, dist_val, n, fmag, k, t, g, amag, base;
      bit              negx, negy, fneg;
      w.vx = 0;
      w.vy = 0;
      w.inr = 0;
      r = radius_reg;
      if (!same && r != 0) begin
        negx = sx < tx;
        negy = sy < ty;
        adx = negx ? tx - sx : sx - tx;
        ady = negy ? ty - sy : sy - ty;
        d2 = adx * adx + ady * ady;
        if (adx <= r && ady <= r && d2 <= r * r) begin
          w.inr = 1;
          dist_val = root(d2);
          if (dist_val != 0) begin
            n = (dist_val << 16) / r;
            fmag = 0;
            fneg = 0;
            if (n < eq_reg) begin
              fmag = 65536 - (n << 16) / eq_reg;
              fneg = 1;
            end else if (n > eq_reg && n < 65536) begin
              base = 65536 + eq_reg;
              t = (2 * n >= base) ? 2 * n - base : base - 2 * n;
              g = 65536 - (t << 16) / (65536 - eq_reg);
              fneg = att[ATT_W-1];
              amag = fneg ? 64'h10000 - att : att;
              fmag = (amag * g) >> 14;
            end
            k = (r * fmag) >> POS_FRAC_BITS;
            w.vx = scale_axis(adx, negx, dist_val, k, fneg);
            w.vy = scale_axis(ady, negy, dist_val, k, fneg);
          end
        end
      end
      pending = {pending, w};
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_word(logic signed [OUT_W-1:0] vx, logic signed [OUT_W-1:0] vy, logic inr);
      force_word_t w;
      if (pending.size() == 0) begin
        report("unexpected word, delta_vx", vx, 0);
        return;
      end
      w = pending.pop_front();
      if (vx !== w.vx) report("delta_vx", vx, w.vx);
      if (vy !== w.vy) report("delta_vy", vy, w.vy);
      if (inr !== w.inr) report("in_range", inr, w.inr);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_EQUILIBRIUM;
  logic [CFG_DATA_W-1:0] cfg_data = 0;
  logic in_valid = 0, in_ready;
  logic [POS_W-1:0] in_source_x = 0, in_source_y = 0, in_target_x = 0, in_target_y = 0;
  logic signed [ATT_W-1:0] in_attraction = 0;
  logic in_same_particle = 0;
  logic out_valid, out_ready = 0;
  logic signed [OUT_W-1:0] out_delta_vx, out_delta_vy;
  logic out_in_range;

  force_scoreboard sb = new();
  int hold_req = 0;
  int burst_left = 0;
  bit no_gaps = 0;

  always #4 clk = ~clk;

  particle_pair_force_kernel dut (.*);

  // receiver: stall pattern is redrawn at random, plus long hold-off on request
  initial begin
    int cyc, mode;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      cyc++;
      if (hold_req > 0) begin
        out_ready = 0;
        hold_req--;
      end else if (mode == 0) begin
        out_ready = 1;
      end else begin
        out_ready = ($urandom_range(0, 99) < (mode == 1 ? 75 : 30));
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_word(out_delta_vx, out_delta_vy, out_in_range);

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task send_pair(logic [POS_W-1:0] sx, logic [POS_W-1:0] sy, logic [POS_W-1:0] tx,
                 logic [POS_W-1:0] ty, logic [ATT_W-1:0] att, bit same);
    int gap;
    if (burst_left == 0 && !no_gaps) begin
      gap = $urandom_range(0, 6);
      in_valid = 0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    in_valid = 1;
    in_source_x = sx;
    in_source_y = sy;
    in_target_x = tx;
    in_target_y = ty;
    in_attraction = att;
    in_same_particle = same;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(sx, sy, tx, ty, att, same);
    @(negedge clk);
  endtask

  // called at a falling edge right after the last accepted word
  task drain;
    in_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function logic [POS_W-1:0] near(logic [POS_W-1:0] p, longint unsigned span);
    longint signed v;
    v = longint'(p) + $urandom_range(0, 32'(2 * span)) - longint'(span);
    if (v < 0) v = 0;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return v[POS_W-1:0];
  endfunction

  function logic [ATT_W-1:0] rand_att();
    return ATT_W'($urandom_range(0, 32768)) - ATT_W'(16384);
  endfunction

  task random_pairs(int count);
    logic [POS_W-1:0] sx, sy;
    longint unsigned span;
    int kind;
    repeat (count) begin
      sx = POS_W'($urandom);
      sy = POS_W'($urandom);
      kind = $urandom_range(0, 99);
      span = (sb.radius_reg * 6) / 5 + 1;
      if (kind < 8) send_pair(sx, sy, sx, sy, rand_att(), 1);
      else if (kind < 25) send_pair(sx, sy, POS_W'($urandom), POS_W'($urandom), rand_att(),
                                    1'($urandom_range(0, 1)));
      else send_pair(sx, sy, near(sx, span), near(sy, span), rand_att(), 0);
    end
  endtask

  task set_regs(int e, int r, int t);
    write_reg(CFG_EQUILIBRIUM, CFG_DATA_W'(e));
    write_reg(CFG_RADIUS, CFG_DATA_W'(r));
    write_reg(CFG_TIME_STEP, CFG_DATA_W'(t));
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1;
    // directed pairs at reset settings (radius one cell)
    send_pair(24'h100000, 24'h100000, 24'h100000, 24'h100000, 16'sd16384, 1);
    send_pair(24'h100000, 24'h100000, 24'h100000, 24'h100000, 16'sd16384, 0);
    send_pair(24'h110000, 24'h100000, 24'h100000, 24'h100000, 16'sd16384, 0);
    send_pair(24'h110001, 24'h100000, 24'h100000, 24'h100000, 16'sd16384, 0);
    send_pair(24'h100000 + 19661, 24'h100000, 24'h100000, 24'h100000, -16'sd16384, 0);
    send_pair(24'h100000 + 40000, 24'h100000, 24'h100000, 24'h100000, 16'sd16384, 0);
    send_pair(24'h100000, 24'h100000 + 40000, 24'h100000, 24'h100000, -16'sd16384, 0);
    send_pair(24'h100000, 24'h100000, 24'h100000 + 30000, 24'h100000 + 30000, 16'sd0, 0);
    send_pair(24'h100000, 24'h100000, 24'h100000 + 1000, 24'h100000 - 500, 16'sd100, 0);
    send_pair(24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 16'sd16384, 0);
    send_pair(24'hFFFFFF, 24'hFFFFFF, 24'hFFFF00, 24'hFFFFF0, -16'sd1, 0);
    send_pair(24'h000000, 24'h000001, 24'h000001, 24'h000000, 16'sd16384, 1);
    drain();
    // zero radius and zero equilibrium
    set_regs(0, 0, 65535);
    send_pair(24'h100000, 24'h100000, 24'h100000, 24'h100000, 16'sd16384, 0);
    send_pair(24'h100000, 24'h100000, 24'h100001, 24'h100000, 16'sd16384, 0);
    drain();
    set_regs(0, 65536, 65535);
    send_pair(24'h100000 + 30000, 24'h100000, 24'h100000, 24'h100000, 16'sd16384, 0);
    send_pair(24'h100000 + 100, 24'h100000, 24'h100000, 24'h100000, -16'sd16384, 0);
    random_pairs(40);
    drain();
    // extreme settings: the largest radius and the smallest nonzero equilibrium
    set_regs(1, 24'hFFFFFF, 65535);
    send_pair(24'h000000, 24'h000000, 24'h000001, 24'h000000, 16'sd16384, 0);
    send_pair(24'h000000, 24'h000000, 24'h800000, 24'h000000, -16'sd16384, 0);
    random_pairs(70);
    drain();
    set_regs(65535, 1, 1);
    random_pairs(50);
    drain();
    set_regs(32768, 24'h040000, 4000);
    // long output hold-off while the sender keeps pushing
    no_gaps = 1;
    hold_req = 400;
    random_pairs(90);
    no_gaps = 0;
    drain();
    set_regs(19661, 24'h008000, 0);
    random_pairs(50);
    drain();
    set_regs($urandom_range(1, 65535), $urandom_range(1, 24'hFFFFFF), $urandom_range(0, 65535));
    random_pairs(70);
    drain();
    set_regs(45000, 24'h200000, 20000);
    random_pairs(70);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
